// ===== rtl/tccg_pkg.sv =====
`default_nettype none

package tccg_pkg;

	localparam int COLUMNS     = 32;
	localparam int ROWS        = 24;
	localparam int GLYPH_COUNT = 128;
	localparam int CELL_COUNT  = COLUMNS * ROWS;
	localparam int GLYPH_BYTES = GLYPH_COUNT * 8;
	localparam int CELL_W      = $clog2(CELL_COUNT);
	localparam int GADDR_W     = $clog2(GLYPH_BYTES);
	localparam int GLYPH_W     = $clog2(GLYPH_COUNT);

	localparam logic [1:0] OP_WR_SCREEN = 2'd0;
	localparam logic [1:0] OP_WR_GLYPH  = 2'd1;
	localparam logic [1:0] OP_CHECK     = 2'd2;

	localparam logic [2:0] LINE_LAST = 3'd7;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] address;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [4:0] cell_column;
		logic [4:0] cell_row;
		logic [2:0] glyph_line;
		logic [7:0] pixels;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COMPARE,
		ST_LINES
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic exec;
		logic update;
		logic glyph_rd;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic is_check;
		logic changed;
		logic line_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/tccg_ctrl.sv =====
`default_nettype none

module tccg_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  tccg_pkg::sts_t    sts,
	output tccg_pkg::cmd_t    cmd
);
	import tccg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = sts.is_check ? ST_COMPARE : ST_IDLE;
			end
			ST_COMPARE: begin
				state_d = sts.changed ? ST_LINES : ST_IDLE;
			end
			ST_LINES: begin
				if (sts.line_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_COMPARE: begin
				cmd.update = sts.changed;
			end
			ST_LINES: begin
				cmd.glyph_rd = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/tccg_dp.sv =====
`default_nettype none

module tccg_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  tccg_pkg::item_t   item,
	input  tccg_pkg::cmd_t    cmd,
	output tccg_pkg::sts_t    sts,
	output logic              strobe,
	output tccg_pkg::result_t result
);
	import tccg_pkg::*;

	logic [7:0] screen_mem [CELL_COUNT];
	logic [7:0] glyph_mem  [GLYPH_BYTES];
	logic [7:0] shown_mem  [CELL_COUNT];

	logic [1:0]        op_q;
	logic [9:0]        addr_q;
	logic [7:0]        data_q;
	logic [CELL_W-1:0] clr_q;
	logic [7:0]        code_q;
	logic [7:0]        shown_q;
	logic [2:0]        line_q;

	logic              strobe_s1;
	logic [7:0]        rd_s1;
	logic              gok_s1;
	logic              inv_s1;
	logic [2:0]        line_s1;
	logic [4:0]        col_s1;
	logic [4:0]        row_s1;

	logic              cell_ok;
	logic              gaddr_ok;
	logic              glyph_ok;
	logic [GADDR_W-1:0] rd_gaddr;
	logic              shown_we;
	logic [CELL_W-1:0] shown_wa;
	logic [7:0]        shown_wd;

	assign cell_ok  = 32'(addr_q) < CELL_COUNT;
	assign gaddr_ok = 32'(addr_q) < GLYPH_BYTES;
	assign glyph_ok = 32'(code_q[6:0]) < GLYPH_COUNT;
	assign rd_gaddr = GADDR_W'({code_q[GLYPH_W-1:0], line_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item.opcode;
			addr_q <= item.address;
			data_q <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// screen memory: write port and registered read for a check
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_WR_SCREEN && cell_ok) begin
			screen_mem[addr_q[CELL_W-1:0]] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			code_q <= screen_mem[addr_q[CELL_W-1:0]];
		end
	end

	// shadow of drawn codes: cleared to all-ones after reset, then updated on redraw
	always_comb begin
		shown_we = cmd.clr_step | cmd.update;
		shown_wa = cmd.clr_step ? clr_q : addr_q[CELL_W-1:0];
		shown_wd = cmd.clr_step ? 8'hff : code_q;
	end

	always_ff @(posedge clk) begin
		if (shown_we) begin
			shown_mem[shown_wa] <= shown_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			shown_q <= shown_mem[addr_q[CELL_W-1:0]];
		end
	end

	// glyph memory
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_WR_GLYPH && gaddr_ok) begin
			glyph_mem[addr_q[GADDR_W-1:0]] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.glyph_rd) begin
			rd_s1 <= glyph_mem[rd_gaddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (cmd.update) begin
			line_q <= '0;
		end else if (cmd.glyph_rd) begin
			line_q <= line_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.glyph_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.glyph_rd) begin
			gok_s1  <= glyph_ok;
			inv_s1  <= code_q[7];
			line_s1 <= line_q;
			col_s1  <= 5'(32'(addr_q) % COLUMNS);
			row_s1  <= 5'(32'(addr_q) / COLUMNS);
		end
	end

	always_comb begin
		sts.clr_done  = 32'(clr_q) == CELL_COUNT - 1;
		sts.is_check  = op_q == OP_CHECK && cell_ok;
		sts.changed   = code_q != shown_q;
		sts.line_last = line_q == LINE_LAST;
	end

	assign strobe             = strobe_s1;
	assign result.cell_column = col_s1;
	assign result.cell_row    = row_s1;
	assign result.glyph_line  = line_s1;
	assign result.pixels      = (gok_s1 ? rd_s1 : 8'h00) ^ {8{inv_s1}};
	assign result.last        = line_s1 == LINE_LAST;

endmodule

`default_nettype wire

// ===== rtl/text_cell_glyph_renderer.sv =====
// Channel   Handshake           Payload     Notes
// item in   start & !busy       item_t      opcode, address, data
// result    strobe, one cycle   result_t    8 per redrawn cell, no back-pressure
//
// Memory writes, out-of-range checks and unused opcodes step through exec
// and back to idle; an unchanged check steps through exec and compare.
// A redrawn cell steps through exec, compare, then one glyph memory read
// per line for 8 lines; each line is shown in the cycle after its read.
// After reset the shadow code memory is swept to all-ones, one entry a
// cycle, and busy stays high until all 768 entries are written.
`default_nettype none

module text_cell_glyph_renderer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  tccg_pkg::item_t     item,
	output logic                strobe,
	output tccg_pkg::result_t   result
);
	import tccg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tccg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tccg_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (strobe),
		.result (result)
	);

endmodule

`default_nettype wire
